// ===== src/flpc_pkg.sv =====
// ----------------------------------------------------------------------------
// flpc_pkg
// Shared constants, types and helpers of the linear-phase FIR crossover.
// ----------------------------------------------------------------------------
package flpc_pkg;

    localparam int ORDER    = 128;
    localparam int CHANNELS = 2;
    localparam int TAPS     = ORDER + 1;
    localparam int DELAY    = ORDER / 2;

    localparam int SAMPLE_W = 24;
    localparam int COEF_W   = 18;
    localparam int TIDX_W   = 8;
    localparam int FRAC     = 17;

    localparam int IDX_W  = $clog2(TAPS);
    localparam int CNT_W  = $clog2(TAPS + 1);
    localparam int PROD_W = SAMPLE_W + COEF_W;
    localparam int ACC_W  = PROD_W + $clog2(TAPS);

    localparam int IN_DATA_W  = 56;
    localparam int IN_USER_W  = 2;
    localparam int OUT_DATA_W = 48;
    localparam int OUT_USER_W = 1;

    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 2;
    localparam logic [APB_ADDR_W-1:0] REG_BYPASS = 2'd0;

    localparam logic signed [ACC_W-1:0] SAT_HI   = ACC_W'(8388607);
    localparam logic signed [ACC_W-1:0] SAT_LO   = -ACC_W'(8388608);
    localparam logic signed [ACC_W-1:0] RND_HALF = ACC_W'(1) <<< (FRAC - 1);

    typedef struct packed {
        logic load;
        logic tap_we;
        logic hist_we;
        logic dly_cap;
        logic mac_clear;
        logic mac_issue;
        logic round;
        logic sat;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic in_is_tap;
        logic in_ch_ok;
        logic bypass;
        logic mac_last;
        logic pipe_busy;
        logic out_free;
    } t_status;

    function automatic logic signed [SAMPLE_W-1:0] sat24(input logic signed [ACC_W-1:0] v);
        logic signed [ACC_W-1:0] r;
        if (v > SAT_HI) begin
            r = SAT_HI;
        end else if (v < SAT_LO) begin
            r = SAT_LO;
        end else begin
            r = v;
        end
        return r[SAMPLE_W-1:0];
    endfunction

endpackage

// ===== src/fir_linear_phase_crossover.sv =====
// ----------------------------------------------------------------------------
// fir_linear_phase_crossover
// Two-channel linear-phase FIR crossover giving complementary low/high bands.
//
// Channel   Dir  Handshake            Contents
// s (in)    in   tvalid/tready        tdata: sample_in[23:0], tap_index[31:24],
//                                     tap_value[49:32]; tuser: action[0], channel[1]
// m (out)   out  tvalid/tready        tdata: low_band[23:0], high_band[47:24];
//                                     tuser: out_channel[0]
// apb       in   psel/penable/pready  0x0 bypass
//
// A sample's processing time is set by the single 18x24 MAC stepping over all ORDER+1
// taps; bypass skips the MAC pass. No new word is accepted until the block is idle.
// Reset clears control only: tap valid bits and per-channel fill counts make
// unwritten taps and history read as zero, so there is no clearing pass.
// The result sits in an output register; a held result stalls the block only
// when the next result is ready to load.
// ----------------------------------------------------------------------------
module fir_linear_phase_crossover (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_s_tvalid,
    output logic                                o_s_tready,
    input  logic [flpc_pkg::IN_DATA_W-1:0]      i_s_tdata,  // sample_in, tap_index, tap_value
    input  logic [flpc_pkg::IN_USER_W-1:0]      i_s_tuser,  // action, channel
    output logic                                o_m_tvalid,
    input  logic                                i_m_tready,
    output logic [flpc_pkg::OUT_DATA_W-1:0]     o_m_tdata,  // low_band, high_band
    output logic [flpc_pkg::OUT_USER_W-1:0]     o_m_tuser,  // out_channel
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [flpc_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [flpc_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [flpc_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready
);

    logic              r_bypass;
    flpc_pkg::t_cmd    cmd;
    flpc_pkg::t_status status;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bypass <= 1'b0;
        end else if (psel && penable && pwrite && (paddr == flpc_pkg::REG_BYPASS)) begin
            r_bypass <= pwdata[0];
        end
    end

    assign prdata = (paddr == flpc_pkg::REG_BYPASS)
                  ? {{(flpc_pkg::APB_DATA_W-1){1'b0}}, r_bypass} : '0;

    flpc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    flpc_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_bypass   (r_bypass),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .i_cmd      (cmd),
        .o_status   (status)
    );

endmodule

// ===== src/flpc_ctrl.sv =====
// ----------------------------------------------------------------------------
// flpc_ctrl
// Sequencer: accepts a word, runs a coefficient write or one MAC pass per non-bypass sample.
// ----------------------------------------------------------------------------
module flpc_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_s_tvalid,
    output logic             o_s_tready,
    input  flpc_pkg::t_status i_status,
    output flpc_pkg::t_cmd   o_cmd
);

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_TAPW  = 9'b000000010,
        S_WRITE = 9'b000000100,
        S_DLY   = 9'b000001000,
        S_MAC   = 9'b000010000,
        S_DRAIN = 9'b000100000,
        S_ROUND = 9'b001000000,
        S_SAT   = 9'b010000000,
        S_OUT   = 9'b100000000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_s_tready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    o_cmd.load = 1'b1;
                    if (i_status.in_is_tap) begin
                        n_state = S_TAPW;
                    end else if (i_status.in_ch_ok) begin
                        n_state = S_WRITE;
                    end
                end
            end
            S_TAPW: begin
                o_cmd.tap_we = 1'b1;
                n_state      = S_IDLE;
            end
            S_WRITE: begin
                o_cmd.hist_we = 1'b1;
                n_state       = S_DLY;
            end
            S_DLY: begin
                o_cmd.dly_cap = 1'b1;
                if (i_status.bypass) begin
                    n_state = S_ROUND;
                end else begin
                    o_cmd.mac_clear = 1'b1;
                    n_state         = S_MAC;
                end
            end
            S_MAC: begin
                o_cmd.mac_issue = 1'b1;
                if (i_status.mac_last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (!i_status.pipe_busy) begin
                    n_state = S_ROUND;
                end
            end
            S_ROUND: begin
                o_cmd.round = 1'b1;
                n_state     = S_SAT;
            end
            S_SAT: begin
                o_cmd.sat = 1'b1;
                n_state   = S_OUT;
            end
            S_OUT: begin
                if (i_status.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// ===== src/flpc_dp.sv =====
// ----------------------------------------------------------------------------
// flpc_dp
// Datapath: tap and history memories, one MAC, rounding, saturation, output.
// ----------------------------------------------------------------------------
module flpc_dp (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_bypass,
    input  logic [flpc_pkg::IN_DATA_W-1:0]      i_s_tdata,
    input  logic [flpc_pkg::IN_USER_W-1:0]      i_s_tuser,
    output logic                                o_m_tvalid,
    input  logic                                i_m_tready,
    output logic [flpc_pkg::OUT_DATA_W-1:0]     o_m_tdata,
    output logic [flpc_pkg::OUT_USER_W-1:0]     o_m_tuser,
    input  flpc_pkg::t_cmd                      i_cmd,
    output flpc_pkg::t_status                   o_status
);

    localparam int SW = flpc_pkg::SAMPLE_W;
    localparam int CW = flpc_pkg::COEF_W;
    localparam int IW = flpc_pkg::IDX_W;
    localparam int NW = flpc_pkg::CNT_W;
    localparam int AW = flpc_pkg::ACC_W;
    localparam int PW = flpc_pkg::PROD_W;
    localparam int OUT_DATA_W_L = flpc_pkg::OUT_DATA_W;

    // input word fields
    logic                         r_ch;
    logic signed [SW-1:0]         r_x;
    logic [flpc_pkg::TIDX_W-1:0]  r_tap_index;
    logic signed [CW-1:0]         r_tap_value;

    // memories
    logic signed [CW-1:0]  r_tap [flpc_pkg::TAPS];
    logic [flpc_pkg::TAPS-1:0] r_tap_vld;
    logic signed [SW-1:0]  r_hist [flpc_pkg::CHANNELS][flpc_pkg::TAPS];
    logic [IW-1:0]         r_wpos [flpc_pkg::CHANNELS];
    logic [NW-1:0]         r_fill [flpc_pkg::CHANNELS];

    // MAC pipeline
    logic [IW-1:0]         r_k;
    logic [IW-1:0]         r_rd_idx;
    logic signed [CW-1:0]  r_tap_q;
    logic                  r_tap_ok;
    logic signed [SW-1:0]  r_hist_q;
    logic                  r_hist_ok;
    logic                  r_v_rd;
    logic signed [PW-1:0]  r_prod;
    logic                  r_v_prod;
    logic signed [AW-1:0]  r_acc;

    logic signed [SW-1:0]  r_delayed;
    logic signed [SW-1:0]  r_low;
    logic signed [SW-1:0]  r_high;

    logic                  r_m_tvalid;
    logic [OUT_DATA_W_L-1:0] r_m_tdata;
    logic                  r_m_ch;

    logic [IW-1:0]         p_cur;
    logic [IW-1:0]         dly_idx;
    logic [IW-1:0]         rd_addr;
    logic                  tap_in_range;
    logic signed [CW-1:0]  tap_m;
    logic signed [SW-1:0]  hist_m;
    logic signed [PW-1:0]  prod_c;
    logic signed [AW-1:0]  rnd_t;
    logic signed [AW-1:0]  rnd_q;
    logic signed [SW:0]    diff;

    assign p_cur = r_wpos[r_ch];
    assign dly_idx = (p_cur >= IW'(flpc_pkg::DELAY)) ? (p_cur - IW'(flpc_pkg::DELAY))
                   : (p_cur + IW'(flpc_pkg::TAPS - flpc_pkg::DELAY));
    assign rd_addr = i_cmd.hist_we ? dly_idx : r_rd_idx;
    assign tap_in_range = (int'(r_tap_index) < flpc_pkg::TAPS);

    assign o_status.in_is_tap = i_s_tuser[0];
    assign o_status.in_ch_ok  = (int'(i_s_tuser[1]) < flpc_pkg::CHANNELS);
    assign o_status.bypass    = i_bypass;
    assign o_status.mac_last  = (r_k == IW'(flpc_pkg::TAPS - 1));
    assign o_status.pipe_busy = r_v_rd | r_v_prod;
    assign o_status.out_free  = !r_m_tvalid | i_m_tready;

    // input capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_x         <= i_s_tdata[SW-1:0];
            r_tap_index <= i_s_tdata[SW +: flpc_pkg::TIDX_W];
            r_tap_value <= i_s_tdata[SW + flpc_pkg::TIDX_W +: CW];
            r_ch        <= i_s_tuser[1];
        end
    end

    // tap table
    always_ff @(posedge i_clk) begin
        if (i_cmd.tap_we && tap_in_range) begin
            r_tap[r_tap_index[IW-1:0]] <= r_tap_value;
        end
        r_tap_q <= r_tap[r_k];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tap_vld <= '0;
            r_tap_ok  <= 1'b0;
        end else begin
            if (i_cmd.tap_we && tap_in_range) begin
                r_tap_vld[r_tap_index[IW-1:0]] <= 1'b1;
            end
            r_tap_ok <= r_tap_vld[r_k];
        end
    end

    // history rings; entries past the fill count read as zero
    always_ff @(posedge i_clk) begin
        if (i_cmd.hist_we) begin
            r_hist[r_ch][p_cur] <= r_x;
        end
        r_hist_q <= r_hist[r_ch][rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < flpc_pkg::CHANNELS; c++) begin
                r_wpos[c] <= '0;
                r_fill[c] <= '0;
            end
            r_hist_ok <= 1'b0;
        end else begin
            if (i_cmd.hist_we) begin
                r_wpos[r_ch] <= (p_cur == IW'(flpc_pkg::TAPS - 1)) ? '0 : p_cur + 1'b1;
                if (r_fill[r_ch] != NW'(flpc_pkg::TAPS)) begin
                    r_fill[r_ch] <= r_fill[r_ch] + 1'b1;
                end
            end
            r_hist_ok <= (NW'(rd_addr) < r_fill[r_ch]);
        end
    end

    // MAC
    assign tap_m  = r_tap_ok  ? r_tap_q  : '0;
    assign hist_m = r_hist_ok ? r_hist_q : '0;
    assign prod_c = tap_m * hist_m;

    always_ff @(posedge i_clk) begin
        if (i_cmd.hist_we) begin
            r_rd_idx <= p_cur;
        end else if (i_cmd.mac_issue) begin
            r_rd_idx <= (r_rd_idx == '0) ? IW'(flpc_pkg::TAPS - 1) : r_rd_idx - 1'b1;
        end
        if (i_cmd.mac_clear) begin
            r_k <= '0;
        end else if (i_cmd.mac_issue) begin
            r_k <= r_k + 1'b1;
        end
        r_prod <= prod_c;
        if (i_cmd.mac_clear) begin
            r_acc <= '0;
        end else if (r_v_prod) begin
            r_acc <= r_acc + AW'(r_prod);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v_rd   <= 1'b0;
            r_v_prod <= 1'b0;
        end else begin
            r_v_rd   <= i_cmd.mac_issue;
            r_v_prod <= r_v_rd;
        end
    end

    // round to nearest, ties up; saturate
    assign rnd_t = r_acc + flpc_pkg::RND_HALF;
    assign rnd_q = rnd_t >>> flpc_pkg::FRAC;
    assign diff  = (SW+1)'(r_delayed) - (SW+1)'(r_low);

    always_ff @(posedge i_clk) begin
        if (i_cmd.dly_cap) begin
            r_delayed <= hist_m;
        end
        if (i_cmd.round) begin
            r_low <= i_bypass ? r_x : flpc_pkg::sat24(rnd_q);
        end
        if (i_cmd.sat) begin
            r_high <= i_bypass ? r_delayed : flpc_pkg::sat24(AW'(diff));
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_tvalid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_m_tvalid <= 1'b1;
        end else if (i_m_tready) begin
            r_m_tvalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_m_tdata <= {r_high, r_low};
            r_m_ch    <= r_ch;
        end
    end

    assign o_m_tvalid = r_m_tvalid;
    assign o_m_tdata  = r_m_tdata;
    assign o_m_tuser  = r_m_ch;

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Stream-level test of the linear-phase FIR crossover. A behavioral model of
// the tap table, the two history rings and the bypass register predicts the
// low/high band word for every accepted sample; the output checker compares
// each word field by field. Directed cases (cleared history, rounding ties,
// tap extremes, out-of-range tap index, bypass) are followed by random traffic
// with bursty input, output stalls and one long output hold-off.
// ----------------------------------------------------------------------------
module tb;

    import flpc_pkg::*;

    localparam logic ACT_SAMPLE    = 1'b0;
    localparam logic ACT_COEF      = 1'b1;
    localparam int   SETTLE_CYCLES = ORDER + 40;
    localparam int   CYCLE_LIMIT   = 2_000_000;
    localparam int   COEF_PCT      = 12;
    localparam int   HOLD_CYCLES   = 1500;

    typedef struct packed {
        logic                       ch;
        logic signed [SAMPLE_W-1:0] low;
        logic signed [SAMPLE_W-1:0] high;
    } t_band;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_s_tvalid;
    logic                   o_s_tready;
    logic [IN_DATA_W-1:0]   i_s_tdata;   // sample_in[23:0], tap_index[31:24], tap_value[49:32]
    logic [IN_USER_W-1:0]   i_s_tuser;   // action[0], channel[1]
    logic                   o_m_tvalid;
    logic                   i_m_tready;
    logic [OUT_DATA_W-1:0]  o_m_tdata;   // low_band[23:0], high_band[47:24]
    logic [OUT_USER_W-1:0]  o_m_tuser;   // out_channel[0]
    logic                   psel;
    logic                   penable;
    logic                   pwrite;
    logic [APB_ADDR_W-1:0]  paddr;
    logic [APB_DATA_W-1:0]  pwdata;
    logic [APB_DATA_W-1:0]  prdata;
    logic                   pready;

    // model state
    logic signed [SAMPLE_W-1:0] hist [CHANNELS][TAPS];
    int                         wpos [CHANNELS];
    logic signed [COEF_W-1:0]   taps [TAPS];
    logic                       bypass_q;

    t_band expected_bands [$];

    int  fail_count;
    int  cycle_count;
    int  words_checked;
    int  samples_sent;
    int  tap_writes;
    int  ignored_writes;
    int  bypass_samples;
    int  rx_stall_max;
    int  hold_req;

    fir_linear_phase_crossover dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d words outstanding",
                     cycle_count, expected_bands.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    function automatic logic rnd_ch();
        return 1'($urandom);
    endfunction

    function automatic logic [SAMPLE_W-1:0] rnd_smp();
        return SAMPLE_W'($urandom);
    endfunction

    function automatic logic [TIDX_W-1:0] rnd_tidx();
        return TIDX_W'($urandom);
    endfunction

    function automatic logic [COEF_W-1:0] rnd_tval();
        return COEF_W'($urandom);
    endfunction

    function automatic longint clamp24(longint v);
        longint hi;
        longint lo;
        hi = (longint'(1) <<< (SAMPLE_W - 1)) - 1;
        lo = -(longint'(1) <<< (SAMPLE_W - 1));
        if (v > hi) begin
            return hi;
        end else if (v < lo) begin
            return lo;
        end
        return v;
    endfunction

    // Pushes the sample into its ring and works out both bands.
    function automatic t_band predict_bands(logic ch, logic signed [SAMPLE_W-1:0] x);
        t_band                      r;
        int                         p;
        int                         c;
        logic signed [SAMPLE_W-1:0] dly;
        longint                     acc;
        longint                     low_l;
        c = int'(ch);
        p = wpos[c];
        hist[c][p] = x;
        dly = hist[c][(p + TAPS - DELAY) % TAPS];
        r.ch = ch;
        if (bypass_q) begin
            r.low  = x;
            r.high = dly;
        end else begin
            acc = 0;
            for (int k = 0; k < TAPS; k++) begin
                acc += longint'(taps[k]) * longint'(hist[c][(p + TAPS - k) % TAPS]);
            end
            low_l  = clamp24((acc + (longint'(1) <<< (FRAC - 1))) >>> FRAC);
            r.low  = SAMPLE_W'(low_l);
            r.high = SAMPLE_W'(clamp24(longint'(dly) - low_l));
        end
        wpos[c] = (p + 1) % TAPS;
        return r;
    endfunction

    always @(posedge i_clk) begin : check_out
        t_band want;
        if (i_rst_n && o_m_tvalid === 1'b1 && i_m_tready) begin
            if (expected_bands.size() == 0) begin
                $error("unexpected band word: ch %0d data %h", o_m_tuser[0], o_m_tdata);
                fail_count++;
            end else begin
                want = expected_bands.pop_front();
                words_checked++;
                if (o_m_tuser[0] !== want.ch) begin
                    $error("out_channel: expected %0d, got %0d", want.ch, o_m_tuser[0]);
                    fail_count++;
                end
                if (o_m_tdata[23:0] !== want.low) begin
                    $error("low_band: expected %0d, got %0d",
                           want.low, $signed(o_m_tdata[23:0]));
                    fail_count++;
                end
                if (o_m_tdata[47:24] !== want.high) begin
                    $error("high_band: expected %0d, got %0d",
                           want.high, $signed(o_m_tdata[47:24]));
                    fail_count++;
                end
            end
        end
    end

    // Output stall pattern; a hold-off request parks tready low for a long stretch.
    initial begin : rx_stall
        int   run_left;
        int   hold_left;
        logic level;
        i_m_tready = 1'b0;
        run_left   = 0;
        hold_left  = 0;
        level      = 1'b1;
        forever begin
            @(negedge i_clk);
            if (hold_req > 0) begin
                hold_left = hold_req;
                hold_req  = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_m_tready <= 1'b0;
            end else begin
                if (run_left == 0) begin
                    level    = (rx_stall_max == 0) ? 1'b1 : ~level;
                    run_left = level ? $urandom_range(1, 24) : $urandom_range(1, rx_stall_max);
                end
                run_left--;
                i_m_tready <= level;
            end
        end
    end

    task automatic send_word(input logic act, input logic ch,
                             input logic [SAMPLE_W-1:0] smp,
                             input logic [TIDX_W-1:0] tidx,
                             input logic [COEF_W-1:0] tval);
        @(negedge i_clk);
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {tval, tidx, smp};
        i_s_tuser  <= {ch, act};
        do @(posedge i_clk); while (o_s_tready !== 1'b1);
        if (act == ACT_COEF) begin
            if (tidx < TAPS) begin
                taps[tidx] = tval;
                tap_writes++;
            end else begin
                ignored_writes++;
            end
        end else begin
            expected_bands.push_back(predict_bands(ch, smp));
            samples_sent++;
            if (bypass_q) begin
                bypass_samples++;
            end
        end
    endtask

    task automatic sender_gap(input int n);
        repeat (n) begin
            @(negedge i_clk);
            i_s_tvalid <= 1'b0;
        end
    endtask

    task automatic wait_idle();
        @(negedge i_clk);
        i_s_tvalid <= 1'b0;
        while (expected_bands.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Write the bypass register, then read it back.
    task automatic set_bypass(input logic val);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= REG_BYPASS;
        pwdata  <= APB_DATA_W'(val);
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        bypass_q = val;
        @(negedge i_clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        if (prdata !== APB_DATA_W'(val)) begin
            $error("bypass readback: expected %0d, got %0d", val, prdata);
            fail_count++;
        end
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic send_random_item(output bit counted);
        logic                act;
        logic [SAMPLE_W-1:0] smp;
        logic [TIDX_W-1:0]   tidx;
        logic [COEF_W-1:0]   tval;
        int                  pick;
        act = ($urandom_range(0, 99) < COEF_PCT) ? ACT_COEF : ACT_SAMPLE;
        pick = $urandom_range(0, 9);
        case (pick)
            0:       smp = 24'h7FFFFF;
            1:       smp = 24'h800000;
            2, 3:    smp = SAMPLE_W'(int'($urandom_range(0, 511)) - 256);
            default: smp = rnd_smp();
        endcase
        tidx = ($urandom_range(0, 9) == 0) ? TIDX_W'($urandom_range(TAPS, 255))
                                           : TIDX_W'($urandom_range(0, TAPS - 1));
        pick = $urandom_range(0, 9);
        if (pick < 7) begin
            tval = COEF_W'(int'($urandom_range(0, 8191)) - 4096);
        end else if (pick < 9) begin
            tval = COEF_W'(int'($urandom_range(0, 65535)) - 32768);
        end else begin
            tval = rnd_tval();
        end
        counted = !(act == ACT_COEF && tidx >= TAPS);
        send_word(act, rnd_ch(), smp, tidx, tval);
    endtask

    task automatic run_random_phase(input int n_items, input int gap_max,
                                    input int stall_max, input logic byp);
        int sent;
        int burst;
        bit counted;
        wait_idle();
        set_bypass(byp);
        rx_stall_max = stall_max;
        sent = 0;
        while (sent < n_items) begin
            burst = $urandom_range(1, 16);
            repeat (burst) begin
                send_random_item(counted);
                sent += counted;
            end
            sender_gap((gap_max == 0) ? 0 : $urandom_range(0, gap_max));
        end
    endtask

    // Taps are all zero after reset: low is zero, high is the delayed input.
    task automatic test_cleared_history();
        rx_stall_max = 0;
        send_word(ACT_SAMPLE, 1'b0, 24'h7FFFFF, rnd_tidx(), rnd_tval());
        send_word(ACT_SAMPLE, 1'b1, 24'h800000, rnd_tidx(), rnd_tval());
        send_word(ACT_SAMPLE, 1'b0, 24'hFFFFFF, rnd_tidx(), rnd_tval());
        send_word(ACT_SAMPLE, 1'b1, 24'h000000, rnd_tidx(), rnd_tval());
    endtask

    // Smallest tap makes halves land exactly on ties; ties round upward.
    task automatic test_round_half();
        send_word(ACT_COEF, rnd_ch(), rnd_smp(), 8'd0, 18'd1);
        send_word(ACT_SAMPLE, 1'b0, 24'd65536, rnd_tidx(), rnd_tval());
        send_word(ACT_SAMPLE, 1'b0, -24'sd65536, rnd_tidx(), rnd_tval());
        send_word(ACT_SAMPLE, 1'b1, 24'd196608, rnd_tidx(), rnd_tval());
        send_word(ACT_SAMPLE, 1'b1, -24'sd196608, rnd_tidx(), rnd_tval());
    endtask

    // Full-scale taps drive the low band into saturation; indexes past ORDER are dropped.
    task automatic test_tap_extremes();
        send_word(ACT_COEF, rnd_ch(), rnd_smp(), 8'd0, 18'h1FFFF);
        send_word(ACT_COEF, rnd_ch(), rnd_smp(), 8'd1, 18'h1FFFF);
        send_word(ACT_COEF, rnd_ch(), rnd_smp(), 8'(ORDER), 18'h20000);
        send_word(ACT_COEF, rnd_ch(), rnd_smp(), 8'(TAPS), 18'h00005);
        send_word(ACT_COEF, rnd_ch(), rnd_smp(), 8'hFF, 18'h3FFFF);
        send_word(ACT_SAMPLE, 1'b0, 24'h7FFFFF, rnd_tidx(), rnd_tval());
        send_word(ACT_SAMPLE, 1'b0, 24'h7FFFFF, rnd_tidx(), rnd_tval());
        send_word(ACT_SAMPLE, 1'b1, 24'h800000, rnd_tidx(), rnd_tval());
        send_word(ACT_SAMPLE, 1'b1, 24'h800000, rnd_tidx(), rnd_tval());
    endtask

    // Bypass still feeds the rings, so the delay line is continuous afterwards.
    task automatic test_bypass_path();
        wait_idle();
        set_bypass(1'b1);
        send_word(ACT_SAMPLE, 1'b0, 24'h800000, rnd_tidx(), rnd_tval());
        send_word(ACT_SAMPLE, 1'b1, 24'h7FFFFF, rnd_tidx(), rnd_tval());
        send_word(ACT_SAMPLE, 1'b0, rnd_smp(), rnd_tidx(), rnd_tval());
        send_word(ACT_SAMPLE, 1'b1, rnd_smp(), rnd_tidx(), rnd_tval());
        wait_idle();
        set_bypass(1'b0);
    endtask

    task automatic test_output_backpressure();
        bit counted;
        wait_idle();
        rx_stall_max = 0;
        hold_req = HOLD_CYCLES;
        repeat (60) send_random_item(counted);
    endtask

    task automatic test_random_traffic();
        run_random_phase(250, 0, 0, 1'b0);
        run_random_phase(200, 150, 40, 1'b0);
        run_random_phase(200, 40, 200, 1'b1);
        run_random_phase(250, 10, 8, 1'b0);
        run_random_phase(150, 80, 0, 1'b0);
    endtask

    initial begin
        i_rst_n    = 1'b0;
        i_s_tvalid = 1'b0;
        i_s_tdata  = '0;
        i_s_tuser  = '0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        fail_count = 0;
        cycle_count = 0;
        words_checked = 0;
        samples_sent = 0;
        tap_writes = 0;
        ignored_writes = 0;
        bypass_samples = 0;
        rx_stall_max = 0;
        hold_req = 0;
        bypass_q = 1'b0;
        for (int c = 0; c < CHANNELS; c++) begin
            wpos[c] = 0;
            for (int k = 0; k < TAPS; k++) hist[c][k] = '0;
        end
        for (int k = 0; k < TAPS; k++) taps[k] = '0;

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_cleared_history();
        test_round_half();
        test_tap_extremes();
        test_bypass_path();
        test_output_backpressure();
        test_random_traffic();

        wait_idle();
        $display("Checked %0d band words from %0d samples (%0d in bypass).",
                 words_checked, samples_sent, bypass_samples);
        $display("Tap writes: %0d stored, %0d out of range; output held off once for %0d cycles.",
                 tap_writes, ignored_writes, HOLD_CYCLES);
        if (fail_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
